FILE: rtl/core/krle_pkg.sv
// ----------------------------------------------------------------------------
// krle_pkg
// Shared types and constants of the keyed run-length row decoder.
// ----------------------------------------------------------------------------
package krle_pkg;

  // Default column counter width (pixels per row up to 2**16 - 1)
  localparam int unsigned ColumnBitsDefault = 16;

  // Configuration register indexes
  localparam int unsigned CfgIdxBits  = 2;
  localparam int unsigned CfgDataBits = 16;

  typedef enum logic [CfgIdxBits-1:0] {
    CfgRowWidth       = 2'd0,
    CfgTransparentKey = 2'd1,
    CfgKeyEnable      = 2'd2,
    CfgSkipRows       = 2'd3
  } cfg_idx_e;

  // Control byte layout
  localparam logic [7:0] CtrlLenMask = 8'h7f;
  localparam logic [7:0] CtrlLitFlag = 8'h80;
  localparam logic [7:0] StreamTerm  = 8'h00;

  // One output span word
  typedef struct packed {
    logic [7:0] pixel_value;
    logic [6:0] span_length;
    logic       write_enable;
    logic       row_end;
    logic       stream_end;
  } span_t;

endpackage

FILE: rtl/core/keyed_rle_row_decoder.sv
// ----------------------------------------------------------------------------
// keyed_rle_row_decoder
// Run-length decoder with literal and repeat runs, transparent key and
// row skipping; one compressed byte in, at most one pixel span out.
// ----------------------------------------------------------------------------
// The decoder takes one compressed byte per clock while in_stall_o is low and
// produces at most one span word for it, registered in the output register,
// or in the skid register while the output stalls. Each accepted byte updates
// the decoder state (phase, run counters and the signed column remainder). A
// two-entry output stage (output register plus skid register) lets input
// bytes keep flowing while a span waits; in_stall_o rises only when both
// entries are full. Configuration writes are always ready; row_width takes
// effect at the next row start, the key settings at the next byte.
module keyed_rle_row_decoder #(
  parameter int unsigned COLUMN_BITS = krle_pkg::ColumnBitsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [krle_pkg::CfgIdxBits-1:0]  cfg_index_i,
  input  logic [krle_pkg::CfgDataBits-1:0] cfg_data_i,
  // compressed byte input
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [7:0]                    stream_byte_i,
  input  logic                          restart_i,
  // span output
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [7:0]                    pixel_value_o,
  output logic [6:0]                    span_length_o,
  output logic                          write_enable_o,
  output logic                          row_end_o,
  output logic                          stream_end_o
);
  import krle_pkg::*;

  localparam int unsigned ColW     = COLUMN_BITS + 1;
  localparam int unsigned LoadBits = (COLUMN_BITS < 16) ? COLUMN_BITS : 16;

  typedef enum logic [1:0] {
    PhCtrl = 2'd0,
    PhLit  = 2'd1,
    PhRep  = 2'd2
  } phase_e;

  // configuration registers
  logic [15:0] row_width_q;
  logic [7:0]  key_q;
  logic        key_en_q;
  logic [15:0] skip_rows_q;

  // decoder state
  phase_e             phase_q, phase_d;
  logic [6:0]         lit_left_q, lit_left_d;
  logic [6:0]         run_len_q, run_len_d;
  logic signed [ColW-1:0] cols_q, cols_d;
  logic               row_start_q, row_start_d;
  logic [15:0]        rows_skip_q, rows_skip_d;
  logic               finished_q, finished_d;

  // output stage
  logic  out_valid_q, skid_valid_q;
  span_t out_q, skid_q;
  span_t res;
  logic  res_valid;

  logic in_accept;
  logic take;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = skid_valid_q;
  assign in_accept   = in_valid_i && !skid_valid_q;
  assign take        = out_valid_q && !out_stall_i;

  // write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_width_q <= 16'd1;
      key_q       <= 8'd0;
      key_en_q    <= 1'b0;
      skip_rows_q <= 16'd0;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CfgRowWidth:       row_width_q <= cfg_data_i;
        CfgTransparentKey: key_q       <= cfg_data_i[7:0];
        CfgKeyEnable:      key_en_q    <= cfg_data_i[0];
        CfgSkipRows:       skip_rows_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // decode one byte against the current (or restarted) state
  always_comb begin
    phase_e                 ph;
    logic [6:0]             lit_e;
    logic [6:0]             run_e;
    logic signed [ColW-1:0] cols_e;
    logic signed [ColW-1:0] cols_n;
    logic                   row_start_e;
    logic [15:0]            skip_e;
    logic                   silent;
    logic                   done;
    logic [6:0]             len;
    logic                   close;

    if (restart_i) begin
      ph          = PhCtrl;
      lit_e       = '0;
      run_e       = '0;
      cols_e      = '0;
      row_start_e = 1'b1;
      skip_e      = skip_rows_q;
    end else begin
      ph          = phase_q;
      lit_e       = lit_left_q;
      run_e       = run_len_q;
      cols_e      = cols_q;
      row_start_e = row_start_q;
      skip_e      = rows_skip_q;
    end

    phase_d     = ph;
    lit_left_d  = lit_e;
    run_len_d   = run_e;
    cols_d      = cols_e;
    row_start_d = row_start_e;
    finished_d  = restart_i ? 1'b0 : finished_q;
    silent      = (skip_e != 16'd0);
    len         = stream_byte_i[6:0] & CtrlLenMask[6:0];
    done        = 1'b0;
    close       = 1'b0;
    cols_n      = cols_e;

    res_valid        = 1'b0;
    res.pixel_value  = stream_byte_i;
    res.span_length  = 7'd1;
    res.write_enable = !(key_en_q && (stream_byte_i == key_q));
    res.row_end      = 1'b0;
    res.stream_end   = 1'b0;

    if (!finished_d) begin
      case (ph)
        PhLit: begin
          lit_left_d = lit_e - 7'd1;
          if (lit_left_d == 7'd0) begin
            phase_d = PhCtrl;
            done    = cols_e[ColW-1] || (cols_e == '0);
          end
          res_valid   = !silent;
          res.row_end = done;
          close       = done;
        end
        PhRep: begin
          phase_d         = PhCtrl;
          done            = cols_e[ColW-1] || (cols_e == '0);
          res_valid       = !silent && (run_e != 7'd0);
          res.span_length = run_e;
          res.row_end     = done;
          close           = done;
        end
        default: begin
          phase_d = PhCtrl;
          if (row_start_e && (stream_byte_i == StreamTerm)) begin
            // terminator at row start ends the stream
            finished_d       = 1'b1;
            res_valid        = 1'b1;
            res.pixel_value  = 8'd0;
            res.span_length  = 7'd0;
            res.write_enable = 1'b0;
            res.stream_end   = 1'b1;
          end else begin
            cols_n = row_start_e ? ColW'(row_width_q[LoadBits-1:0]) : cols_e;
            cols_n = cols_n - ColW'(len);
            row_start_d = 1'b0;
            cols_d      = cols_n;
            if ((stream_byte_i & CtrlLitFlag) != 8'd0) begin
              lit_left_d = len;
              if (len == 7'd0) begin
                close = cols_n[ColW-1] || (cols_n == '0);
              end else begin
                phase_d = PhLit;
              end
            end else begin
              run_len_d = len;
              phase_d   = PhRep;
            end
          end
        end
      endcase
    end

    // close the row
    rows_skip_d = skip_e;
    if (close) begin
      row_start_d = 1'b1;
      if (skip_e != 16'd0) begin
        rows_skip_d = skip_e - 16'd1;
      end
    end
  end

  // hold decoder state, advance on accepted word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhCtrl;
      lit_left_q  <= '0;
      run_len_q   <= '0;
      cols_q      <= '0;
      row_start_q <= 1'b1;
      rows_skip_q <= '0;
      finished_q  <= 1'b0;
    end else if (in_accept) begin
      phase_q     <= phase_d;
      lit_left_q  <= lit_left_d;
      run_len_q   <= run_len_d;
      cols_q      <= cols_d;
      row_start_q <= row_start_d;
      rows_skip_q <= rows_skip_d;
      finished_q  <= finished_d;
    end
  end

  // output register and skid register control
  logic new_word;
  logic out_free;
  assign new_word = in_accept && res_valid;
  assign out_free = take || !out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q  <= skid_valid_q || new_word;
      skid_valid_q <= 1'b0;
    end else if (new_word) begin
      skid_valid_q <= 1'b1;
    end
  end

  // output and skid payload
  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (new_word) begin
        out_q <= res;
      end
    end else if (new_word) begin
      skid_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign pixel_value_o  = out_q.pixel_value;
  assign span_length_o  = out_q.span_length;
  assign write_enable_o = out_q.write_enable;
  assign row_end_o      = out_q.row_end;
  assign stream_end_o   = out_q.stream_end;

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the keyed run-length row decoder. A queue of
// compressed bytes feeds a clocked driver. Each accepted byte is decoded by a
// local span predictor, and the expected spans are compared field by field
// with the span words taken by a clocked monitor. Phases change the register
// settings between drained runs and vary the idling on both sides.
// ----------------------------------------------------------------------------
module tb_top;
  import krle_pkg::*;

  localparam int unsigned CycleLimit = 600000;
  localparam int unsigned MaxPrints  = 100;

  typedef enum logic [1:0] {
    PhCtrl = 2'd0,
    PhLit  = 2'd1,
    PhRep  = 2'd2
  } dec_phase_e;

  typedef struct packed {
    logic [7:0] data;
    logic       restart;
  } stream_word_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic       cfg_valid = 1'b0;
  cfg_idx_e   cfg_index = CfgRowWidth;
  logic [15:0] cfg_data = '0;
  logic       cfg_ready_o;

  logic       in_valid    = 1'b0;
  logic [7:0] stream_byte = '0;
  logic       restart     = 1'b0;
  logic       in_stall_o;

  logic       out_valid_o;
  logic       out_stall = 1'b0;
  logic [7:0] pixel_value_o;
  logic [6:0] span_length_o;
  logic       write_enable_o;
  logic       row_end_o;
  logic       stream_end_o;

  keyed_rle_row_decoder i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall_o),
    .stream_byte_i  (stream_byte),
    .restart_i      (restart),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall),
    .pixel_value_o  (pixel_value_o),
    .span_length_o  (span_length_o),
    .write_enable_o (write_enable_o),
    .row_end_o      (row_end_o),
    .stream_end_o   (stream_end_o)
  );

  // Bench state
  stream_word_t pending_bytes[$];
  span_t        expected_spans[$];
  stream_word_t next_word;
  span_t        want_span;
  int           err_cnt       = 0;
  int           cycle_cnt     = 0;
  int           send_idle_pct = 0;
  int           stall_pct     = 0;
  int           budget        = 0;
  int           gen_width     = 1;
  logic [7:0]   gen_key       = '0;

  // Register copies of the predictor
  logic [15:0] row_width_q  = 16'd1;
  logic [7:0]  key_q        = '0;
  logic        key_en_q     = 1'b0;
  logic [15:0] skip_rows_q  = '0;

  // Decoder state of the predictor
  dec_phase_e  dec_phase    = PhCtrl;
  logic [6:0]  literal_left = '0;
  logic [6:0]  run_len      = '0;
  int          columns_left = 0;
  logic        at_row_start = 1'b1;
  logic [15:0] rows_to_skip = '0;
  logic        stream_done  = 1'b0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic report_mismatch(string what, int got, int want);
    // keep the log short on a badly broken block, but count every miss
    if (err_cnt < MaxPrints) begin
      $display("[%0t] mismatch %0s: got %0d, want %0d", $realtime, what, got, want);
    end
    err_cnt++;
  endtask

  // Queue one expected span; key-valued pixels turn into skip spans
  task automatic push_span(logic [7:0] val, logic [6:0] len, logic row_done);
    span_t s;
    s.pixel_value  = val;
    s.span_length  = len;
    s.write_enable = !(key_en_q && (val == key_q));
    s.row_end      = row_done;
    s.stream_end   = 1'b0;
    expected_spans.push_back(s);
  endtask

  task automatic close_row();
    at_row_start = 1'b1;
    if (rows_to_skip != 0) rows_to_skip--;
  endtask

  // Advance the span predictor by one accepted byte
  task automatic decode_byte(logic [7:0] b, logic rs);
    logic  silent;
    logic  row_done;
    span_t term;
    if (rs) begin
      dec_phase    = PhCtrl;
      literal_left = '0;
      run_len      = '0;
      columns_left = 0;
      at_row_start = 1'b1;
      stream_done  = 1'b0;
      rows_to_skip = skip_rows_q;
    end
    if (stream_done) return;
    silent = (rows_to_skip != 0);
    case (dec_phase)
      PhLit: begin
        literal_left = literal_left - 7'd1;
        row_done = 1'b0;
        if (literal_left == 0) begin
          dec_phase = PhCtrl;
          row_done  = (columns_left <= 0);
        end
        if (!silent) push_span(b, 7'd1, row_done);
        if (row_done) close_row();
      end
      PhRep: begin
        dec_phase = PhCtrl;
        row_done  = (columns_left <= 0);
        if (!silent && run_len != 0) push_span(b, run_len, row_done);
        if (row_done) close_row();
      end
      default: begin
        dec_phase = PhCtrl;
        if (at_row_start) begin
          // terminator at a row start ends the image, even while skipping
          if (b == StreamTerm) begin
            stream_done       = 1'b1;
            term              = '0;
            term.stream_end   = 1'b1;
            expected_spans.push_back(term);
            return;
          end
          columns_left = int'(row_width_q);
          at_row_start = 1'b0;
        end
        columns_left -= int'(b & CtrlLenMask);
        if ((b & CtrlLitFlag) != 0) begin
          literal_left = b[6:0];
          if (literal_left == 0) begin
            if (columns_left <= 0) close_row();
          end else begin
            dec_phase = PhLit;
          end
        end else begin
          run_len   = b[6:0];
          dec_phase = PhRep;
        end
      end
    endcase
  endtask

  // Driver: predict on acceptance, then load the next word or go idle
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall_o) decode_byte(stream_byte, restart);
      if (!in_valid || !in_stall_o) begin
        if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_word   = pending_bytes.pop_front();
          in_valid    <= 1'b1;
          stream_byte <= next_word.data;
          restart     <= next_word.restart;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each taken span word against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall) begin
      if (expected_spans.size() == 0) begin
        report_mismatch("unexpected span, pixel", int'(pixel_value_o), -1);
      end else begin
        want_span = expected_spans.pop_front();
        if (pixel_value_o !== want_span.pixel_value)
          report_mismatch("pixel_value", int'(pixel_value_o),
                          int'(want_span.pixel_value));
        if (span_length_o !== want_span.span_length)
          report_mismatch("span_length", int'(span_length_o),
                          int'(want_span.span_length));
        if (write_enable_o !== want_span.write_enable)
          report_mismatch("write_enable", int'(write_enable_o),
                          int'(want_span.write_enable));
        if (row_end_o !== want_span.row_end)
          report_mismatch("row_end", int'(row_end_o), int'(want_span.row_end));
        if (stream_end_o !== want_span.stream_end)
          report_mismatch("stream_end", int'(stream_end_o),
                          int'(want_span.stream_end));
      end
    end
    out_stall <= rst_ni && ($urandom_range(99) < stall_pct);
  end

  task automatic push_item(logic [7:0] b, logic rs, bit counted);
    stream_word_t w;
    w.data    = b;
    w.restart = rs;
    pending_bytes.push_back(w);
    if (counted) budget--;
  endtask

  // Hold until the input side is empty and every expected span has come
  task automatic wait_drained();
    while (pending_bytes.size() != 0 || in_valid || expected_spans.size() != 0)
      @(posedge clk_i);
    // a last byte may cause no span and still be in flight
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [15:0] data);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid <= 1'b0;
    case (idx)
      CfgRowWidth:       row_width_q = data;
      CfgTransparentKey: key_q       = data[7:0];
      CfgKeyEnable:      key_en_q    = data[0];
      CfgSkipRows:       skip_rows_q = data;
      default: ;
    endcase
  endtask

  // Write all registers; upper data bits of the narrow ones are noise
  task automatic set_config(int width, logic [7:0] key, logic en, int skip);
    logic [7:0] junk;
    junk = 8'($urandom_range(255));
    write_reg(CfgRowWidth, width[15:0]);
    write_reg(CfgTransparentKey, {junk, key});
    write_reg(CfgKeyEnable, {junk, 7'($urandom_range(127)), en});
    write_reg(CfgSkipRows, skip[15:0]);
    gen_width = width;
    gen_key   = key;
  endtask

  function automatic logic [7:0] pick_pixel();
    return ($urandom_range(3) == 0) ? gen_key : 8'($urandom_range(255));
  endfunction

  function automatic int pick_len();
    int r;
    r = $urandom_range(99);
    if (r < 5) return 0;
    if (r < 10) return 127;
    if (r < 20) return $urandom_range(126, 13);
    return $urandom_range(12, 1);
  endfunction

  // One well-formed image with random content, now and then cut short
  task automatic gen_image();
    int   rows;
    int   rem;
    int   len;
    logic lit;
    logic first;
    logic row_first;
    rows  = $urandom_range(4, 1);
    first = 1'b1;
    for (int r = 0; r < rows && budget > 0; r++) begin
      rem       = gen_width;
      row_first = 1'b1;
      do begin
        lit = 1'($urandom_range(1));
        len = pick_len();
        // a zero repeat control at a row start would end the stream
        if (row_first && !lit && len == 0) lit = 1'b1;
        push_item({lit, 7'(len)}, first, 1'b1);
        first     = 1'b0;
        row_first = 1'b0;
        if (lit) begin
          for (int k = 0; k < len; k++) push_item(pick_pixel(), 1'b0, 1'b1);
        end else begin
          push_item(pick_pixel(), 1'b0, 1'b1);
        end
        rem -= len;
        if ($urandom_range(49) == 0) return;
      end while (rem > 0 && budget > 0);
    end
    push_item(StreamTerm, first, 1'b1);
    // trailing bytes after the terminator are dropped by the block
    repeat ($urandom_range(2)) push_item(8'($urandom_range(255)), 1'b0, 1'b0);
  endtask

  task automatic gen_noise();
    repeat ($urandom_range(8, 1))
      push_item(8'($urandom_range(255)), $urandom_range(7) == 0, 1'b1);
  endtask

  task automatic run_phase(int n, int idle_pct, int stl_pct);
    send_idle_pct = idle_pct;
    stall_pct     = stl_pct;
    budget        = n;
    while (budget > 0) begin
      if ($urandom_range(9) == 0) gen_noise();
      else gen_image();
    end
    wait_drained();
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed, reset settings: decoding starts without a restart
    push_item(8'h81, 1'b0, 1'b1);   // literal of one, extreme pixel
    push_item(8'hff, 1'b0, 1'b1);
    push_item(8'h05, 1'b0, 1'b1);   // repeat with overshoot
    push_item(8'h00, 1'b0, 1'b1);
    push_item(8'h7f, 1'b0, 1'b1);   // longest repeat
    push_item(8'haa, 1'b0, 1'b1);
    push_item(8'h83, 1'b0, 1'b1);
    push_item(8'h01, 1'b0, 1'b1);
    push_item(8'h80, 1'b0, 1'b1);
    push_item(8'h7e, 1'b0, 1'b1);
    push_item(8'h80, 1'b0, 1'b1);   // empty literal leaves the row open
    push_item(8'h00, 1'b0, 1'b1);   // empty repeat still eats its value
    push_item(8'h11, 1'b0, 1'b1);
    push_item(8'h81, 1'b0, 1'b1);
    push_item(8'h22, 1'b0, 1'b1);
    push_item(StreamTerm, 1'b0, 1'b1);
    push_item(8'h44, 1'b0, 1'b0);   // dropped after the terminator
    push_item(StreamTerm, 1'b1, 1'b1);
    wait_drained();

    // Directed: zero width, key on, two skipped rows
    set_config(0, 8'h5a, 1'b1, 2);
    push_item(8'h82, 1'b1, 1'b1);   // silent row
    push_item(8'h5a, 1'b0, 1'b1);
    push_item(8'h10, 1'b0, 1'b1);
    push_item(8'h80, 1'b0, 1'b1);   // empty literal closes a zero-width row
    push_item(8'h03, 1'b0, 1'b1);
    push_item(8'h5a, 1'b0, 1'b1);   // key pixel becomes a skip span
    push_item(StreamTerm, 1'b0, 1'b1);
    push_item(StreamTerm, 1'b1, 1'b1); // terminator while rows are skipped
    wait_drained();

    // Random phases; each drains fully before the next settings go in
    set_config(1, 8'h00, 1'b1, 0);
    run_phase(350, 0, 0);
    set_config($urandom_range(20, 5), 8'($urandom_range(255)), 1'b1, 1);
    run_phase(350, 76, 0);
    set_config(65535, 8'($urandom_range(255)), 1'b1, 0);
    run_phase(150, 0, 76);
    set_config($urandom_range(300, 30), 8'($urandom_range(255)), 1'b0, 65535);
    run_phase(100, 0, 0);
    set_config($urandom_range(40, 1), 8'($urandom_range(255)), 1'b1, 0);
    run_phase(350, 6, 6);
    set_config($urandom_range(10, 1), 8'hff, 1'b1, 3);
    run_phase(300, 0, 0);

    repeat (10) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
